@@ rtl/assert_macros.svh @@
// assertion macros used by the segment intersection core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, held off during rst
`define SEGI_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on clk, held off during rst
`define SEGI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/segi_pkg.sv @@
// shared types and constants of the segment intersection core
`default_nettype none

package segi_pkg;

  localparam int IN_W      = 16;  // width of each input coordinate field
  localparam int IN_FIELDS = 8;   // coordinate fields per input item
  localparam int OUT_W     = 24;  // width of each crossing coordinate

  // control that travels beside the divider payload
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } segi_ctl_t;

endpackage

`default_nettype wire

@@ rtl/segment_intersection_core.sv @@
// top level of the segment intersection core
// usage:
//   input channel s_*: one item per handshake, two segments a and b, eight
//   signed coordinates in s_tdata; an item is taken when s_tvalid and s_tready
//   are both high at a rising edge of clk
//   output channel m_*: one result item per input item, in order; m_tuser is
//   the hit flag, m_tdata holds the crossing point in fixed point, both
//   coordinates zero on a miss
// throughput: one item every cycle, sustained, as long as m_tready stays high
// pipeline: the divider resolves one quotient bit per stage over COORD_BITS +
//   FRAC_BITS stages, behind seven stages of differences, products, sign
//   handling and numerator build, and ahead of the output register
// reset: rst is synchronous, active high; it empties every stage and the
//   output buffer, nothing else holds state
// stall: a two-entry output buffer absorbs one result once m_tready drops;
//   s_tready then falls in the next cycle and the whole pipeline holds, so
//   no item is lost or repeated
`default_nettype none
`include "assert_macros.svh"

module segment_intersection_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (16 bits each)
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cross_x [23:0], cross_y [47:24]
  output logic [47:0]  m_tdata,
  // hit
  output logic         m_tuser
);

  localparam int C     = COORD_BITS;
  localparam int DF_W  = C + 1;           // coordinate differences
  localparam int PR_W  = 2 * DF_W;        // cross products
  localparam int D_W   = PR_W + 1;        // denominator and numerators
  localparam int DM_W  = 2 * C + 1;       // denominator magnitude
  localparam int NP_W  = C + DM_W + 2;    // point products
  localparam int NS_W  = NP_W + 1;        // point numerator
  localparam int NW    = NS_W + FRAC_BITS;
  localparam int QW    = C + FRAC_BITS;   // quotient magnitude
  localparam int QS_W  = QW + 1;
  localparam int OW    = segi_pkg::OUT_W;
  localparam int IW    = segi_pkg::IN_W;

  // global advance: the pipeline moves while the spare buffer is empty
  logic en;
  logic spare_v;
  assign en       = !spare_v;
  assign s_tready = en;

  // field decode: two's complement when COORD_BITS <= IN_W, else zero-extended
  logic signed [C-1:0] crd [segi_pkg::IN_FIELDS];
  if (C <= IW) begin : g_narrow
    always_comb begin
      for (int k = 0; k < segi_pkg::IN_FIELDS; k++) begin
        crd[k] = $signed(s_tdata[k*IW +: C]);
      end
    end
  end else begin : g_wide
    always_comb begin
      for (int k = 0; k < segi_pkg::IN_FIELDS; k++) begin
        crd[k] = $signed({{(C-IW){1'b0}}, s_tdata[k*IW +: IW]});
      end
    end
  end

  // stage 1: differences
  logic                   v1;
  logic signed [DF_W-1:0] dxa1, dya1, dxb1, dyb1, ox1, oy1;
  logic signed [C-1:0]    x1_1, y1_1;

  // stage 2: cross products
  logic                   v2;
  logic signed [PR_W-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [DF_W-1:0] dxa2, dya2;
  logic signed [C-1:0]    x1_2, y1_2;

  // stage 3: denominator and numerators
  logic                   v3;
  logic signed [D_W-1:0]  d3, na3, nb3;
  logic signed [DF_W-1:0] dxa3, dya3;
  logic signed [C-1:0]    x1_3, y1_3;

  // stage 4: sign normalised, range test
  logic                   v4, hit4;
  logic [DM_W-1:0]        dm4, nam4;
  logic signed [DF_W-1:0] dxa4, dya4;
  logic signed [C-1:0]    x1_4, y1_4;

  // stage 5: point products
  logic                   v5, hit5;
  logic [DM_W-1:0]        dm5;
  logic signed [C+DM_W:0] mx0, my0;
  logic signed [NP_W-1:0] mx1, my1;

  // stage 6: point numerators
  logic                   v6, hit6;
  logic [DM_W-1:0]        dm6;
  logic signed [NS_W-1:0] nx6, ny6;

  // stage 7: magnitude, scaled, split for the divider
  segi_pkg::segi_ctl_t    ctl7;
  logic [DM_W-1:0]        dm7;
  logic [DM_W-1:0]        rx7, ry7;
  logic [QW-1:0]          wx7, wy7;

  // combinational helpers
  logic signed [D_W-1:0]  dn, nan, nbn;
  logic signed [DM_W:0]   dms, nams;
  logic [NS_W-1:0]        magx, magy;
  logic [NW-1:0]          shx, shy;

  always_comb begin
    dn   = d3[D_W-1] ? -d3 : d3;
    nan  = d3[D_W-1] ? -na3 : na3;
    nbn  = d3[D_W-1] ? -nb3 : nb3;
    dms  = $signed({1'b0, dm4});
    nams = $signed({1'b0, nam4});
    magx = nx6[NS_W-1] ? (~nx6 + 1'b1) : nx6;
    magy = ny6[NS_W-1] ? (~ny6 + 1'b1) : ny6;
    shx  = NW'(magx) << FRAC_BITS;
    shy  = NW'(magy) << FRAC_BITS;
  end

  // valid bits and control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      ctl7 <= '0;
    end else if (en) begin
      v1         <= s_tvalid;
      v2         <= v1;
      v3         <= v2;
      v4         <= v3;
      v5         <= v4;
      v6         <= v5;
      ctl7.valid <= v6;
      ctl7.hit   <= hit6;
      ctl7.neg_x <= nx6[NS_W-1];
      ctl7.neg_y <= ny6[NS_W-1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dxa1 <= DF_W'(crd[2]) - DF_W'(crd[0]);
      dya1 <= DF_W'(crd[3]) - DF_W'(crd[1]);
      dxb1 <= DF_W'(crd[6]) - DF_W'(crd[4]);
      dyb1 <= DF_W'(crd[7]) - DF_W'(crd[5]);
      ox1  <= DF_W'(crd[0]) - DF_W'(crd[4]);
      oy1  <= DF_W'(crd[1]) - DF_W'(crd[5]);
      x1_1 <= crd[0];
      y1_1 <= crd[1];

      p1   <= PR_W'(dyb1) * PR_W'(dxa1);
      p2   <= PR_W'(dxb1) * PR_W'(dya1);
      p3   <= PR_W'(dxb1) * PR_W'(oy1);
      p4   <= PR_W'(dyb1) * PR_W'(ox1);
      p5   <= PR_W'(dxa1) * PR_W'(oy1);
      p6   <= PR_W'(dya1) * PR_W'(ox1);
      dxa2 <= dxa1;
      dya2 <= dya1;
      x1_2 <= x1_1;
      y1_2 <= y1_1;

      d3   <= D_W'(p1) - D_W'(p2);
      na3  <= D_W'(p3) - D_W'(p4);
      nb3  <= D_W'(p5) - D_W'(p6);
      dxa3 <= dxa2;
      dya3 <= dya2;
      x1_3 <= x1_2;
      y1_3 <= y1_2;

      // hit needs a non-zero denominator and both parameters within the span
      hit4 <= (d3 != '0) && !nan[D_W-1] && (nan <= dn) && !nbn[D_W-1] && (nbn <= dn);
      dm4  <= dn[DM_W-1:0];
      nam4 <= nan[DM_W-1:0];
      dxa4 <= dxa3;
      dya4 <= dya3;
      x1_4 <= x1_3;
      y1_4 <= y1_3;

      mx0  <= (NP_W-1)'(x1_4) * (NP_W-1)'(dms);
      my0  <= (NP_W-1)'(y1_4) * (NP_W-1)'(dms);
      mx1  <= NP_W'(nams) * NP_W'(dxa4);
      my1  <= NP_W'(nams) * NP_W'(dya4);
      dm5  <= dm4;
      hit5 <= hit4;

      nx6  <= NS_W'(mx0) + NS_W'(mx1);
      ny6  <= NS_W'(my0) + NS_W'(my1);
      dm6  <= dm5;
      hit6 <= hit5;

      // quotient fits in QW bits, so the top part is already below the divisor
      rx7  <= shx[QW +: DM_W];
      ry7  <= shy[QW +: DM_W];
      wx7  <= shx[QW-1:0];
      wy7  <= shy[QW-1:0];
      dm7  <= dm6;
    end
  end

  // divider
  segi_pkg::segi_ctl_t ctl_q;
  logic [QW-1:0]       qx, qy;

  segi_div_pipe #(
    .DM_W (DM_W),
    .QW   (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl7),
    .d_in     (dm7),
    .rem_x_in (rx7),
    .w_x_in   (wx7),
    .rem_y_in (ry7),
    .w_y_in   (wy7),
    .ctl_out  (ctl_q),
    .q_x      (qx),
    .q_y      (qy)
  );

  // sign restored, wrapped or sign-extended to the output width, cleared on a miss
  logic signed [QS_W-1:0] sqx, sqy;
  logic [OW-1:0]          cx, cy;
  logic [OW-1:0]          px, py;

  always_comb begin
    sqx = ctl_q.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    sqy = ctl_q.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  end

  if (QS_W >= OW) begin : g_trunc
    assign cx = sqx[OW-1:0];
    assign cy = sqy[OW-1:0];
  end else begin : g_sext
    assign cx = {{(OW-QS_W){sqx[QS_W-1]}}, sqx};
    assign cy = {{(OW-QS_W){sqy[QS_W-1]}}, sqy};
  end

  assign px = ctl_q.hit ? cx : '0;
  assign py = ctl_q.hit ? cy : '0;

  // output register with one spare entry
  logic          out_v;
  logic          out_hit, spare_hit;
  logic [2*OW-1:0] out_d, spare_d;
  logic          take;

  assign take = out_v && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v   <= 1'b0;
      spare_v <= 1'b0;
    end else begin
      if (!out_v || take) begin
        if (spare_v) begin
          out_v   <= 1'b1;
          spare_v <= 1'b0;
        end else begin
          out_v <= ctl_q.valid;
        end
      end else if (en && ctl_q.valid) begin
        spare_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || take) begin
      if (spare_v) begin
        out_d   <= spare_d;
        out_hit <= spare_hit;
      end else begin
        out_d   <= {py, px};
        out_hit <= ctl_q.hit;
      end
    end else if (en && ctl_q.valid) begin
      spare_d   <= {py, px};
      spare_hit <= ctl_q.hit;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_d;
  assign m_tuser  = out_hit;

  // a held spare implies a waiting output
  `SEGI_ASSERT(a_spare_behind_out, spare_v, out_v)
  // a miss always carries a zero point
  `SEGI_ASSERT(a_miss_zero, out_v && !out_hit, out_d == '0)
  // an undrained spare keeps its item
  `SEGI_ASSERT_NEXT(a_spare_holds, spare_v && !take, spare_v && $stable(spare_d))
  // a result arriving at a blocked output lands in the spare
  `SEGI_ASSERT_NEXT(a_spare_fill, en && ctl_q.valid && out_v && !m_tready, spare_v)

endmodule

`default_nettype wire

@@ rtl/segi_div_pipe.sv @@
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage
`default_nettype none

module segi_div_pipe #(
  parameter int DM_W = 33,
  parameter int QW   = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  segi_pkg::segi_ctl_t ctl_in,
  input  logic [DM_W-1:0]     d_in,
  input  logic [DM_W-1:0]     rem_x_in,
  input  logic [QW-1:0]       w_x_in,
  input  logic [DM_W-1:0]     rem_y_in,
  input  logic [QW-1:0]       w_y_in,
  output segi_pkg::segi_ctl_t ctl_out,
  output logic [QW-1:0]       q_x,
  output logic [QW-1:0]       q_y
);

  // stage registers
  segi_pkg::segi_ctl_t ctl_r [QW];
  logic [DM_W-1:0]     d_r   [QW];
  logic [DM_W-1:0]     rem_r [QW][2];
  logic [QW-1:0]       w_r   [QW][2];

  // stage inputs and results
  segi_pkg::segi_ctl_t ctl_c [QW];
  logic [DM_W-1:0]     d_c   [QW];
  logic [DM_W-1:0]     rem_c [QW][2];
  logic [QW-1:0]       w_c   [QW][2];
  logic [DM_W:0]       trial [QW][2];
  logic                ge    [QW][2];
  logic [DM_W:0]       diff  [QW][2];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        ctl_c[i]    = ctl_in;
        d_c[i]      = d_in;
        rem_c[i][0] = rem_x_in;
        rem_c[i][1] = rem_y_in;
        w_c[i][0]   = w_x_in;
        w_c[i][1]   = w_y_in;
      end else begin
        ctl_c[i]    = ctl_r[i-1];
        d_c[i]      = d_r[i-1];
        rem_c[i][0] = rem_r[i-1][0];
        rem_c[i][1] = rem_r[i-1][1];
        w_c[i][0]   = w_r[i-1][0];
        w_c[i][1]   = w_r[i-1][1];
      end
      for (int l = 0; l < 2; l++) begin
        trial[i][l] = {rem_c[i][l], w_c[i][l][QW-1]};
        ge[i][l]    = trial[i][l] >= {1'b0, d_c[i]};
        diff[i][l]  = trial[i][l] - {1'b0, d_c[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW; i++) begin
      if (rst) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        d_r[i] <= d_c[i];
        for (int l = 0; l < 2; l++) begin
          rem_r[i][l] <= ge[i][l] ? diff[i][l][DM_W-1:0] : trial[i][l][DM_W-1:0];
          w_r[i][l]   <= {w_c[i][l][QW-2:0], ge[i][l]};
        end
      end
    end
  end

  assign ctl_out = ctl_r[QW-1];
  assign q_x     = w_r[QW-1][0];
  assign q_y     = w_r[QW-1][1];

endmodule

`default_nettype wire

@@ tb/tb_segment_intersection_core.sv @@
// testbench of the segment intersection core: directed and random segment pairs
`timescale 1ns / 1ps
`default_nettype none

class crossing_scoreboard;
  typedef struct {
    logic        hit;
    logic [23:0] cx;
    logic [23:0] cy;
  } crossing_t;

  crossing_t pending[$];
  int        errors;

  // fixed-point crossing coordinate, truncated toward zero
  function automatic logic [23:0] coord(longint c0, longint dc, longint na, longint d);
    longint num;
    longint q;
    num = (c0 * d + na * dc) * 256;
    q = num / d;
    return q[23:0];
  endfunction

  function void note_item(logic [127:0] data);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint dxa, dya, dxb, dyb, ox, oy, d, na, nb;
    crossing_t e;
    x1 = longint'($signed(data[15:0]));    y1 = longint'($signed(data[31:16]));
    x2 = longint'($signed(data[47:32]));   y2 = longint'($signed(data[63:48]));
    x3 = longint'($signed(data[79:64]));   y3 = longint'($signed(data[95:80]));
    x4 = longint'($signed(data[111:96]));  y4 = longint'($signed(data[127:112]));
    dxa = x2 - x1; dya = y2 - y1; dxb = x4 - x3; dyb = y4 - y3;
    ox = x1 - x3;  oy = y1 - y3;
    d  = dyb * dxa - dxb * dya;
    na = dxb * oy - dyb * ox;
    nb = dxa * oy - dya * ox;
    e = '{1'b0, 24'd0, 24'd0};
    if (d != 0) begin
      if (d < 0) begin
        d = -d; na = -na; nb = -nb;
      end
      if (na >= 0 && na <= d && nb >= 0 && nb <= d) begin
        e.hit = 1'b1;
        e.cx = coord(x1, dxa, na, d);
        e.cy = coord(y1, dya, na, d);
      end
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic hit, logic [47:0] data);
    crossing_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result hit=%0b data=%h", $time, hit, data);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (hit !== e.hit) begin
      $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
      errors++;
    end
    if (data[23:0] !== e.cx) begin
      $display("%0t: cross_x expected %h actual %h", $time, e.cx, data[23:0]);
      errors++;
    end
    if (data[47:24] !== e.cy) begin
      $display("%0t: cross_y expected %h actual %h", $time, e.cy, data[47:24]);
      errors++;
    end
  endfunction
endclass

module tb_segment_intersection_core;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic         m_tuser;

  crossing_scoreboard sb = new();
  bit           calm = 1'b0;    // no idling in the final stretch
  int           cycles = 0;

  segment_intersection_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // accepted items on both sides, sampled at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && s_tvalid && s_tready) sb.note_item(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    if (cycles > 400000) begin
      $display("segment_intersection_core regression: fail");
      $finish;
    end
  end

  // receiver drops m_tready at random, in bursts of random length, until calm is set
  initial begin
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // hold one item on the bus until taken, with an optional gap before it
  task automatic send_item(logic [127:0] data);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_segments(logic [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    send_item({by1, bx1, by0, bx0, ay1, ax1, ay0, ax0});
  endtask

  // small coordinates give frequent crossings, full range gives the extremes
  function automatic logic [15:0] rand_coord(bit narrow);
    if (narrow) return 16'($signed($urandom_range(0, 64)) - 32);
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] c[8];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // crossing in the middle, endpoint touches, parallel, collinear, degenerate, near misses, full-range extremes
    send_segments(0, 0, 10, 10, 0, 10, 10, 0);
    send_segments(0, 0, 10, 0, 10, 0, 10, 10);
    send_segments(0, 0, 10, 0, 0, 0, 0, -10);
    send_segments(0, 0, 10, 0, 0, 5, 10, 5);
    send_segments(0, 0, 10, 0, 2, 0, 20, 0);
    send_segments(3, 3, 3, 3, 0, 0, 10, 10);
    send_segments(3, 3, 3, 3, 3, 3, 3, 3);
    send_segments(0, 0, 10, 0, 11, -5, 11, 5);
    send_segments(0, 0, 3, 7, 0, 5, 7, -1);
    send_segments(-7, 1, 2, -5, 1, 3, -4, -9);
    send_segments(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_segments(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_segments(16'h8000, 0, 16'h7fff, 1, 0, 16'h8000, 1, 16'h7fff);
    send_segments(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 0);
    send_segments(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0, 0);

    // drain before random traffic
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < 2000; n++) begin
      bit narrow;
      narrow = ($urandom_range(0, 3) != 0);
      foreach (c[k]) c[k] = rand_coord(narrow);
      if ($urandom_range(0, 15) == 0) c[2] = c[0];  // vertical or degenerate A
      if (n == 1000) begin
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      if (n == 1700) calm = 1'b1;
      send_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0) begin
      $display("segment_intersection_core regression: pass");
    end else begin
      $display("segment_intersection_core regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
